// File: rtl/core/positional_insert_delete_array_unit_defines.svh
// assertion macros for the positional insert/delete array unit
// no dependencies; included by the top-level rtl file, which checks its own logic
`ifndef POSITIONAL_INSERT_DELETE_ARRAY_UNIT_DEFINES_SVH
`define POSITIONAL_INSERT_DELETE_ARRAY_UNIT_DEFINES_SVH

// check a property on every rising edge outside of reset
`define PIDA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check an implication whose consequent is checked in the cycle after the antecedent
`define PIDA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/pida_pkg.sv
// shared types and constants for the positional insert/delete array unit
// no dependencies
`default_nettype none

package pida_pkg;

  localparam int POS_W          = 5;
  localparam int VAL_W          = 32;
  localparam int CNT_OUT_W      = 5;
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } pida_op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } pida_status_e;

  // command broadcast to every cell of the row
  typedef struct packed {
    logic             ins;
    logic             del;
    logic             rd;
    logic [POS_W-1:0] pos;
  } pida_cmd_t;

endpackage

`default_nettype wire

// File: rtl/core/positional_insert_delete_array_unit.sv
// top level of the positional insert/delete array unit: control, cell row, result register
// depends on pida_pkg, pida_ctrl, pida_cell and the assertion macro header
//
// Every entry lives in its own cell of a row of CAPACITY cells; an insert or delete moves
// all later cells by one in the same clock, and a read picks the addressed cell through an
// OR across the row. A new word is accepted every cycle as long as the result register is
// empty or being drained by out_tready. The result of a word appears in the next cycle.
// Only the fill count and the output valid flag are reset, so the unit is ready as soon as
// reset is released.
`default_nettype none
`include "positional_insert_delete_array_unit_defines.svh"

module positional_insert_delete_array_unit
  import pida_pkg::*;
#(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [39:0] in_tdata,   // op[1:0], position[6:2], value[38:7], zero[39]
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [39:0] out_tdata   // status[1:0], read_value[33:2], fill_count[38:34], zero[39]
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  pida_op_e              in_op;
  logic [POS_W-1:0]      in_position;
  logic signed [VAL_W-1:0] in_value;
  logic                  in_acc;
  pida_cmd_t             cmd;
  pida_status_e          status;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_nxt;
  logic [DATA_WIDTH-1:0] ins_word;
  logic [DATA_WIDTH-1:0] cell_q  [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd [CAPACITY];
  logic [DATA_WIDTH-1:0] rd_word;

  logic                  out_valid_r;
  pida_status_e          status_r;
  logic [VAL_W-1:0]      rd_val_r;
  logic [CNT_OUT_W-1:0]  fill_r;

  assign in_op       = pida_op_e'(in_tdata[1:0]);
  assign in_position = in_tdata[6:2];
  assign in_value    = in_tdata[38:7];
  assign ins_word    = DATA_WIDTH'(in_value);

  assign in_tready = rst_n && (!out_valid_r || out_tready);
  assign in_acc    = in_tvalid && in_tready;

  pida_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc_i     (in_acc),
    .op_i      (in_op),
    .pos_i     (in_position),
    .cmd_o     (cmd),
    .status_o  (status),
    .cnt_o     (cnt),
    .cnt_nxt_o (cnt_nxt)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pida_cell #(
      .IDX        (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk        (clk),
      .cmd_i      (cmd),
      .ins_word_i (ins_word),
      .left_i     (cell_q[(i == 0) ? 0 : i - 1]),
      .right_i    (cell_q[(i == CAPACITY - 1) ? i : i + 1]),
      .data_o     (cell_q[i]),
      .rd_o       (cell_rd[i])
    );
  end

  always_comb begin
    rd_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_word = rd_word | cell_rd[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      status_r <= status;
      rd_val_r <= VAL_W'(rd_word);
      fill_r   <= CNT_OUT_W'(cnt_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, fill_r, rd_val_r, status_r};

  `PIDA_ASSERT(a_cnt_cap, int'(cnt) <= CAPACITY, "fill count above capacity")
  `PIDA_ASSERT_NEXT(a_ins_grow, in_acc && cmd.ins, cnt == $past(cnt) + CNT_W'(1),
    "insert did not grow fill count")
  `PIDA_ASSERT_NEXT(a_idle_hold, !in_acc, cnt == $past(cnt), "fill count moved without a word")
  `PIDA_ASSERT(a_rd_zero, !out_valid_r || status_r == ST_OK || rd_val_r == '0,
    "nonzero read value with error status")
  `PIDA_ASSERT(a_one_op, !(cmd.ins && cmd.del), "insert and delete at once")

endmodule

`default_nettype wire

// File: rtl/core/pida_cell.sv
// one storage cell of the array row: holds one entry, shifts to and from neighbors
// depends on pida_pkg
`default_nettype none

module pida_cell
  import pida_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  wire logic                  clk,
  input  wire pida_cmd_t             cmd_i,
  input  wire logic [DATA_WIDTH-1:0] ins_word_i,
  input  wire logic [DATA_WIDTH-1:0] left_i,
  input  wire logic [DATA_WIDTH-1:0] right_i,
  output      logic [DATA_WIDTH-1:0] data_o,
  output      logic [DATA_WIDTH-1:0] rd_o
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  at_pos;
  logic                  past_pos;

  assign at_pos   = (int'(cmd_i.pos) == IDX);
  assign past_pos = (IDX > int'(cmd_i.pos));

  always_comb begin
    data_nxt = data_r;
    if (cmd_i.ins && at_pos) begin
      data_nxt = ins_word_i;
    end else if (cmd_i.ins && past_pos) begin
      data_nxt = left_i;
    end else if (cmd_i.del && (at_pos || past_pos)) begin
      data_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;
  assign rd_o   = (cmd_i.rd && at_pos) ? data_r : '0;

endmodule

`default_nettype wire

// File: rtl/core/pida_ctrl.sv
// fill count and operation check: decides status and the command for the cell row
// depends on pida_pkg
`default_nettype none

module pida_ctrl
  import pida_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             acc_i,
  input  wire pida_op_e         op_i,
  input  wire logic [POS_W-1:0] pos_i,
  output      pida_cmd_t        cmd_o,
  output      pida_status_e     status_o,
  output      logic [CNT_W-1:0] cnt_o,
  output      logic [CNT_W-1:0] cnt_nxt_o
);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             pos_gt;
  logic             pos_ge;
  logic             full;

  assign pos_gt = int'(pos_i) > int'(cnt_r);
  assign pos_ge = int'(pos_i) >= int'(cnt_r);
  assign full   = int'(cnt_r) >= CAPACITY;

  always_comb begin
    cmd_o     = '0;
    cmd_o.pos = pos_i;
    status_o  = ST_OK;
    cnt_nxt   = cnt_r;
    case (op_i)
      OP_CLEAR: begin
        cnt_nxt = '0;
      end
      OP_INSERT: begin
        if (pos_gt) begin
          status_o = ST_RANGE;
        end else if (full) begin
          status_o = ST_FULL;
        end else begin
          cmd_o.ins = acc_i;
          cnt_nxt   = cnt_r + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (pos_ge) begin
          status_o = ST_RANGE;
        end else begin
          cmd_o.del = acc_i;
          cnt_nxt   = cnt_r - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (pos_ge) begin
          status_o = ST_RANGE;
        end else begin
          cmd_o.rd = 1'b1;
        end
      end
      default: begin
        status_o = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (acc_i) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign cnt_o     = cnt_r;
  assign cnt_nxt_o = cnt_nxt;

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
// self-checking bench for positional_insert_delete_array_unit: directed and random
// clear/insert/delete/read words with a shadow copy of the array and fill count
// depends on pida_pkg and the unit's rtl

module tb;
  import pida_pkg::*;

  localparam int CAP         = DEF_CAPACITY;
  localparam int RAND_WORDS  = 600;
  localparam int DRAIN_EVERY = 150;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    pida_op_e    op;
    logic [4:0]  position;
    logic [31:0] value;
    bit          drain_first;
  } array_word_t;

  typedef struct {
    pida_status_e status;
    logic [31:0]  read_value;
    logic [4:0]   fill_count;
  } array_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // op[1:0], position[6:2], value[38:7], zero[39]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // status[1:0], read_value[33:2], fill_count[38:34], zero[39]

  array_word_t   stim_q[$];
  array_result_t expected_q[$];
  array_word_t   cur_word;

  logic [31:0] shadow_words [CAP];
  int          shadow_count = 0;
  int          gen_count = 0;
  bit          pending_drain = 0;

  int errors = 0;
  int checked = 0;
  int cycles = 0;
  int op_seen [4];
  int status_seen [3];

  positional_insert_delete_array_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow array: result of one word and the state it leaves behind
  function automatic array_result_t apply_to_shadow(array_word_t w);
    array_result_t res;
    int pos;
    int k;
    pos = w.position;
    res.status = ST_OK;
    res.read_value = '0;
    case (w.op)
      OP_CLEAR: shadow_count = 0;
      OP_INSERT: begin
        if (pos > shadow_count) begin
          res.status = ST_RANGE;
        end else if (shadow_count >= CAP) begin
          res.status = ST_FULL;
        end else begin
          for (k = shadow_count; k > pos; k--) shadow_words[k] = shadow_words[k-1];
          shadow_words[pos] = w.value;
          shadow_count++;
        end
      end
      OP_DELETE: begin
        if (pos >= shadow_count) begin
          res.status = ST_RANGE;
        end else begin
          for (k = pos; k + 1 < shadow_count; k++) shadow_words[k] = shadow_words[k+1];
          shadow_count--;
        end
      end
      default: begin
        if (pos >= shadow_count) res.status = ST_RANGE;
        else res.read_value = shadow_words[pos];
      end
    endcase
    res.fill_count = shadow_count[4:0];
    return res;
  endfunction

  task automatic queue_word(pida_op_e op, int pos, logic [31:0] val);
    array_word_t w;
    w.op = op;
    w.position = pos[4:0];
    w.value = val;
    w.drain_first = pending_drain;
    pending_drain = 0;
    stim_q.push_back(w);
    case (op)
      OP_CLEAR:  gen_count = 0;
      OP_INSERT: if (pos <= gen_count && gen_count < CAP) gen_count++;
      OP_DELETE: if (pos < gen_count) gen_count--;
      default: ;
    endcase
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'h0;
      4: return $urandom_range(0, 15) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_index();
    if (gen_count == 0 || $urandom_range(0, 9) == 0) return $urandom_range(gen_count, 31);
    return $urandom_range(0, gen_count - 1);
  endfunction

  // driver
  always @(posedge clk) begin : driver
    int gap_left;
    int burst_left;
    bit load;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      gap_left = 0;
      burst_left = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        array_result_t r;
        r = apply_to_shadow(cur_word);
        expected_q.push_back(r);
        op_seen[cur_word.op]++;
        status_seen[r.status]++;
      end
      if (!in_tvalid || in_tready) begin
        load = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0 &&
                     !(stim_q[0].drain_first && expected_q.size() != 0)) begin
          cur_word = stim_q.pop_front();
          load = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
        in_tvalid <= load;
        if (load) in_tdata <= {1'b0, cur_word.value, cur_word.position, cur_word.op};
      end
    end
  end

  // monitor
  always @(posedge clk) begin : monitor
    array_result_t want;
    int mode;
    int mode_left;
    int stall_run;
    bit ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
      mode = 0;
      mode_left = 0;
      stall_run = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        checked++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected: %h", $time, out_tdata);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_tdata[1:0] !== want.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, out_tdata[1:0]);
            errors++;
          end
          if (out_tdata[33:2] !== want.read_value) begin
            $display("%0t: read_value mismatch: expected %h, actual %h",
                     $time, want.read_value, out_tdata[33:2]);
            errors++;
          end
          if (out_tdata[38:34] !== want.fill_count) begin
            $display("%0t: fill_count mismatch: expected %0d, actual %0d",
                     $time, want.fill_count, out_tdata[38:34]);
            errors++;
          end
        end
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(32, 128);
      end
      mode_left--;
      case (mode)
        0: ready = 1'b1;
        1: ready = $urandom_range(0, 1);
        2: ready = ($urandom_range(0, 4) == 0);
        default: ready = ~out_tready;
      endcase
      if (stall_run >= 12) ready = 1'b1;
      stall_run = ready ? 0 : stall_run + 1;
      out_tready <= ready;
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d words queued, %0d results outstanding",
               $time, stim_q.size(), expected_q.size());
      $display("positional_insert_delete_array_unit regression: fail");
      $finish;
    end
  end

  initial begin
    int directed_n;
    int r;
    int n;
    int k;
    int next_drain;

    // empty array
    queue_word(OP_READ, 0, 32'h1234_5678);
    queue_word(OP_DELETE, 0, 32'h0);
    queue_word(OP_INSERT, 1, 32'h1);
    // front, end and middle inserts with extreme words
    queue_word(OP_INSERT, 0, 32'h8000_0000);
    queue_word(OP_INSERT, 1, 32'h7fff_ffff);
    queue_word(OP_INSERT, 0, 32'hffff_ffff);
    queue_word(OP_INSERT, 2, 32'h0);
    for (k = 0; k < 4; k++) queue_word(OP_READ, k, 32'hdead_beef);
    queue_word(OP_READ, 4, 32'h0);
    queue_word(OP_READ, 31, 32'h0);
    queue_word(OP_INSERT, 31, 32'h5555_5555);
    queue_word(OP_DELETE, 31, 32'h0);
    // middle, front and end deletes
    queue_word(OP_DELETE, 1, 32'h0);
    queue_word(OP_DELETE, 0, 32'h0);
    queue_word(OP_DELETE, 1, 32'h0);
    queue_word(OP_READ, 0, 32'h0);
    queue_word(OP_CLEAR, 17, 32'hffff_ffff);
    queue_word(OP_READ, 0, 32'h0);
    queue_word(OP_INSERT, 0, 32'h5a5a_5a5a);
    queue_word(OP_READ, 0, 32'h0);
    directed_n = stim_q.size();
    pending_drain = 1;
    next_drain = DRAIN_EVERY;

    while (stim_q.size() < directed_n + RAND_WORDS) begin
      if (stim_q.size() - directed_n >= next_drain) begin
        pending_drain = 1;
        next_drain += DRAIN_EVERY;
      end
      r = $urandom_range(0, 9);
      if (r < 3) begin
        // build a fresh array by appending, sometimes up to and past full
        queue_word(OP_CLEAR, $urandom_range(0, 31), $urandom);
        n = $urandom_range(1, 18);
        for (k = 0; k < n; k++) queue_word(OP_INSERT, gen_count, pick_value());
        if (gen_count == CAP) queue_word(OP_INSERT, $urandom_range(0, 31), pick_value());
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) queue_word(OP_READ, pick_index(), $urandom);
      end else if (r < 8) begin
        n = $urandom_range(4, 20);
        for (k = 0; k < n; k++) begin
          r = $urandom_range(0, 19);
          if (r == 0) begin
            queue_word(OP_CLEAR, $urandom_range(0, 31), $urandom);
          end else if (r <= 8) begin
            if ($urandom_range(0, 9) == 0)
              queue_word(OP_INSERT, gen_count + 1 + $urandom_range(0, 2), pick_value());
            else
              queue_word(OP_INSERT, $urandom_range(0, gen_count), pick_value());
          end else if (r <= 13) begin
            queue_word(OP_DELETE, pick_index(), $urandom);
          end else begin
            queue_word(OP_READ, pick_index(), $urandom);
          end
        end
      end else begin
        n = $urandom_range(2, 8);
        for (k = 0; k < n; k++)
          queue_word(pida_op_e'($urandom_range(0, 3)), $urandom_range(0, 31), $urandom);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (stim_q.size() != 0 || in_tvalid || expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d results checked: %0d clear, %0d insert, %0d delete, %0d read",
             checked, op_seen[OP_CLEAR], op_seen[OP_INSERT], op_seen[OP_DELETE],
             op_seen[OP_READ]);
    $display("status ok %0d, out of range %0d, array full %0d, errors %0d",
             status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_FULL], errors);
    if (errors == 0) begin
      $display("positional_insert_delete_array_unit regression: pass");
    end else begin
      $display("positional_insert_delete_array_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/pida_pkg.sv
rtl/core/pida_cell.sv
rtl/core/pida_ctrl.sv
rtl/core/positional_insert_delete_array_unit.sv
bench/tb.sv
